>>> sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

>>> sv/wcg_pkg.sv
// types, constants and helpers for the window coefficient generator
`timescale 1ns / 1ps
`default_nettype none
package wcg_pkg;

	localparam int MAX_FRAME = 4096;
	localparam int DIV_STG   = 16;
	localparam int COS_LAT   = 15;
	localparam int PIPE_LAT  = DIV_STG + 1 + COS_LAT + 5;

	// register indexes
	localparam logic REG_WINDOW_TYPE = 1'b0;
	localparam logic REG_FRAME_SIZE  = 1'b1;

	// window types
	localparam logic [1:0] WIN_HANN     = 2'd0;
	localparam logic [1:0] WIN_BLACKMAN = 2'd1;
	localparam logic [1:0] WIN_HAMMING  = 2'd2;
	localparam logic [1:0] WIN_BHARRIS  = 2'd3;

	// cosine weights in units of 1e-5
	localparam logic [16:0] WIN_A [4][4] = '{
		'{17'd50000, 17'd50000, 17'd0,     17'd0},
		'{17'd42000, 17'd50000, 17'd8000,  17'd0},
		'{17'd53836, 17'd46164, 17'd0,     17'd0},
		'{17'd35875, 17'd48829, 17'd14128, 17'd1168}
	};

	localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

	// horner divisors and their reciprocals in q32
	localparam logic [6:0] COS_DIV [4] = '{7'd56, 7'd30, 7'd12, 7'd2};
	localparam logic [6:0] SIN_DIV [4] = '{7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [31:0] COS_RCP [4] = '{
		32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 30),
		32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)
	};
	localparam logic [31:0] SIN_RCP [4] = '{
		32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
		32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)
	};

	// output scaling: divide by 1638400000 = 2^19 * 3125, round half up
	localparam logic [29:0] COEF_HALF  = 30'd819200000;
	localparam logic [11:0] COEF_ODD   = 12'd3125;
	localparam logic [27:0] Y_MAX      = 28'd204803125;
	localparam logic [17:0] RCP_Y      = 18'((64'd1 << 29) / 3125);
	localparam logic [16:0] COEF_ONE   = 17'd65536;

	typedef struct packed {
		logic [29:0] t2;
		logic [29:0] th;
		logic        sin;
		logic        neg;
	} cos_ctx_t;

	typedef struct packed {
		logic [12:0] rem;
		logic [1:0]  bits;
	} div_step_t;

	// two restoring division steps
	function automatic div_step_t div_step2(input logic [12:0] rem, input logic [12:0] den);
		logic [13:0] t;
		logic [12:0] r;
		div_step_t   res;
		r = rem;
		res.bits = 2'b00;
		for (int i = 0; i < 2; i++) begin
			t = {r, 1'b0};
			res.bits = {res.bits[0], 1'b0};
			if (t >= {1'b0, den}) begin
				t = t - {1'b0, den};
				res.bits[0] = 1'b1;
			end
			r = t[12:0];
		end
		res.rem = r;
		return res;
	endfunction

endpackage
`default_nettype wire

>>> sv/wcg_cos.sv
// pipelined cosine of a q32 phase, signed q30 result
`timescale 1ns / 1ps
`default_nettype none
module wcg_cos import wcg_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [31:0] cos_val
);

	logic [1:0]  quad;
	logic [29:0] r0;
	logic        fold;
	logic [29:0] r_fold;

	logic [29:0] r_s1;
	logic        sin_s1, neg_s1;
	logic [29:0] th_s2;
	logic        sin_s2, neg_s2;
	cos_ctx_t    ctx_s3;

	logic [62:0] prod_th;
	logic [59:0] prod_sq;

	cos_ctx_t    ctx_a_s [1:3];
	logic [29:0] x_a_s   [1:3];
	cos_ctx_t    ctx_b_s [4];
	logic [29:0] x_b_s   [4];
	logic [29:0] q0_b_s  [4];
	cos_ctx_t    ctx_c_s [4];
	logic [30:0] v_c_s   [4];

	logic [60:0] prod_f;
	logic [30:0] mag;

	// octant reduction
	always_comb begin
		quad   = phase[31:30];
		r0     = phase[29:0];
		fold   = r0 > 30'h2000_0000;
		r_fold = fold ? 30'(31'h4000_0000 - {1'b0, r0}) : r0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= r_fold;
			sin_s1 <= quad[0] ^ fold;
			neg_s1 <= quad[0] ^ quad[1];
		end
	end

	assign prod_th = 63'(r_s1) * 63'(TWO_PI_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			th_s2  <= prod_th[61:32];
			sin_s2 <= sin_s1;
			neg_s2 <= neg_s1;
		end
	end

	assign prod_sq = 60'(th_s2) * 60'(th_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3.t2  <= prod_sq[59:30];
			ctx_s3.th  <= th_s2;
			ctx_s3.sin <= sin_s2;
			ctx_s3.neg <= neg_s2;
		end
	end

	// horner steps: multiply, reciprocal multiply, correct
	for (genvar k = 0; k < 4; k++) begin : g_step
		logic [29:0] x_in;
		cos_ctx_t    ctx_in;
		logic [31:0] rcp;
		logic [61:0] prod_m;
		logic [6:0]  dv;
		logic [36:0] qd;
		logic [29:0] rem;
		logic [29:0] q_fix;

		if (k == 0) begin : g_first
			assign x_in   = ctx_s3.t2;
			assign ctx_in = ctx_s3;
		end else begin : g_mul
			logic [60:0] pv;
			assign pv = 61'(ctx_c_s[k-1].t2) * 61'(v_c_s[k-1]);
			always_ff @(posedge clk) begin
				if (en) begin
					x_a_s[k]   <= pv[59:30];
					ctx_a_s[k] <= ctx_c_s[k-1];
				end
			end
			assign x_in   = x_a_s[k];
			assign ctx_in = ctx_a_s[k];
		end

		assign rcp    = ctx_in.sin ? SIN_RCP[k] : COS_RCP[k];
		assign prod_m = 62'(x_in) * 62'(rcp);

		always_ff @(posedge clk) begin
			if (en) begin
				x_b_s[k]   <= x_in;
				q0_b_s[k]  <= prod_m[61:32];
				ctx_b_s[k] <= ctx_in;
			end
		end

		always_comb begin
			dv    = ctx_b_s[k].sin ? SIN_DIV[k] : COS_DIV[k];
			qd    = 37'(q0_b_s[k]) * 37'(dv);
			rem   = x_b_s[k] - qd[29:0];
			q_fix = (rem >= 30'(dv)) ? q0_b_s[k] + 30'd1 : q0_b_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_c_s[k]   <= 31'h4000_0000 - 31'(q_fix);
				ctx_c_s[k] <= ctx_b_s[k];
			end
		end
	end

	assign prod_f = 61'(ctx_c_s[3].th) * 61'(v_c_s[3]);
	assign mag    = ctx_c_s[3].sin ? {1'b0, prod_f[59:30]} : v_c_s[3];

	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= ctx_c_s[3].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule
`default_nettype wire

>>> sv/window_coefficient_generator.sv
// window coefficient generator top level
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   sample_index
//  m_axis   out  m_axis_tvalid/m_axis_tready   coefficient, index_out_of_range
//  cfg      in   cfg_valid/cfg_ready           register write
//
// one index per cycle unless the output stalls; 16 divider stages for the phase,
// one phase stage, 15 cosine stages, 5 weighting and scaling stages
// the whole pipeline advances on one enable; it moves whenever the output
// register is empty or taken, so a stall holds every stage in place
// reset clears the valid bits and sets window type hann, frame size 1024
// cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module window_coefficient_generator import wcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [11:0] sample_index
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [16:0] coefficient
	output logic [0:0]  m_axis_tuser,  // [0] index_out_of_range
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	logic [1:0]  win_type_q;
	logic [12:0] frame_size_q;

	logic [12:0] size;
	logic [12:0] den;
	logic        den_zero;
	logic        en;
	logic [12:0] n_ext;
	logic [12:0] rem_init;

	logic [PIPE_LAT-1:0] vld_s;
	logic [PIPE_LAT-1:0] oor_s;

	logic [12:0] div_rem_s [DIV_STG];
	logic [31:0] div_quo_s [DIV_STG];

	logic [31:0] ph1_s, ph2_s, ph3_s;
	logic signed [31:0] c1, c2, c3;

	logic signed [49:0] term1_s1, term2_s1, term3_s1;
	logic signed [50:0] acc_s2;
	logic signed [50:0] sum_r;
	logic [31:0]        y_raw;
	logic [27:0]        y_s3;
	logic               pos_s3;
	logic [45:0]        prod_y;
	logic [27:0]        y_s4;
	logic [16:0]        q0_s4;
	logic               pos_s4;
	logic [28:0]        qd_y;
	logic [27:0]        rem_y;
	logic [16:0]        q_fix;
	logic [16:0]        coef_s5;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_type_q   <= WIN_HANN;
			frame_size_q <= 13'd1024;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WINDOW_TYPE: win_type_q   <= cfg_data[1:0];
				REG_FRAME_SIZE:  frame_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the user must keep configuration static while items are in flight; not enforced here
	always_comb begin
		size     = (frame_size_q > 13'(MAX_FRAME)) ? 13'(MAX_FRAME) : frame_size_q;
		den      = (win_type_q == WIN_HAMMING) ? size + 13'd1 : size - 13'd1;
		den_zero = den == 13'd0;
		n_ext    = {1'b0, s_axis_tdata[11:0]};
		// index equal to the divisor wraps the phase to zero
		rem_init = (n_ext >= den) ? n_ext - den : n_ext;
	end

	assign en            = !vld_s[PIPE_LAT-1] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_LAT-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s <= {oor_s[PIPE_LAT-2:0], n_ext >= size};
		end
	end

	// phase divider, two quotient bits a stage
	for (genvar i = 0; i < DIV_STG; i++) begin : g_div
		div_step_t st;
		if (i == 0) begin : g_head
			assign st = div_step2(rem_init, den);
			always_ff @(posedge clk) begin
				if (en) begin
					div_rem_s[i] <= st.rem;
					div_quo_s[i] <= {30'd0, st.bits};
				end
			end
		end else begin : g_body
			assign st = div_step2(div_rem_s[i-1], den);
			always_ff @(posedge clk) begin
				if (en) begin
					div_rem_s[i] <= st.rem;
					div_quo_s[i] <= {div_quo_s[i-1][29:0], st.bits};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (den_zero) begin
				ph1_s <= '0;
				ph2_s <= '0;
				ph3_s <= '0;
			end else begin
				ph1_s <= div_quo_s[DIV_STG-1];
				ph2_s <= {div_quo_s[DIV_STG-1][30:0], 1'b0};
				ph3_s <= div_quo_s[DIV_STG-1] + {div_quo_s[DIV_STG-1][30:0], 1'b0};
			end
		end
	end

	wcg_cos u_cos1 (.clk(clk), .en(en), .phase(ph1_s), .cos_val(c1));
	wcg_cos u_cos2 (.clk(clk), .en(en), .phase(ph2_s), .cos_val(c2));
	wcg_cos u_cos3 (.clk(clk), .en(en), .phase(ph3_s), .cos_val(c3));

	always_ff @(posedge clk) begin
		if (en) begin
			term1_s1 <= 50'($signed({1'b0, WIN_A[win_type_q][1]})) * 50'(c1);
			term2_s1 <= 50'($signed({1'b0, WIN_A[win_type_q][2]})) * 50'(c2);
			term3_s1 <= 50'($signed({1'b0, WIN_A[win_type_q][3]})) * 50'(c3);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s2 <= 51'($signed({1'b0, WIN_A[win_type_q][0], 30'd0}))
				- 51'(term1_s1) + 51'(term2_s1) - 51'(term3_s1);
		end
	end

	always_comb begin
		sum_r = acc_s2 + 51'(COEF_HALF);
		y_raw = sum_r[50:19];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s3 <= acc_s2 > 51'sd0;
			y_s3   <= (y_raw > 32'(Y_MAX)) ? Y_MAX : y_raw[27:0];
		end
	end

	assign prod_y = 46'(y_s3) * 46'(RCP_Y);

	always_ff @(posedge clk) begin
		if (en) begin
			q0_s4  <= prod_y[45:29];
			y_s4   <= y_s3;
			pos_s4 <= pos_s3;
		end
	end

	always_comb begin
		qd_y  = 29'(q0_s4) * 29'(COEF_ODD);
		rem_y = y_s4 - qd_y[27:0];
		q_fix = (rem_y >= 28'(COEF_ODD)) ? q0_s4 + 17'd1 : q0_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (oor_s[PIPE_LAT-2] || !pos_s4) begin
				coef_s5 <= '0;
			end else begin
				coef_s5 <= (q_fix > COEF_ONE) ? COEF_ONE : q_fix;
			end
		end
	end

	assign m_axis_tvalid = vld_s[PIPE_LAT-1];
	assign m_axis_tdata  = {7'd0, coef_s5};
	assign m_axis_tuser  = oor_s[PIPE_LAT-1];

	`ASSERT_AT(a_oor_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser[0] |-> coef_s5 == 17'd0, "out of range index gave a nonzero coefficient")
	`ASSERT_NEVER(a_coef_max, clk, arst_n, m_axis_tvalid && coef_s5 > COEF_ONE, "coefficient above one")
	`ASSERT_AT(a_cfg_idle, clk, arst_n, cfg_valid |-> vld_s == '0, "configuration written with items in flight")
	`ASSERT_AT(a_div_rem, clk, arst_n, vld_s[DIV_STG-1] && !oor_s[DIV_STG-1] && !den_zero |-> div_rem_s[DIV_STG-1] < den, "phase divider remainder not below divisor")

endmodule
`default_nettype wire
